// ----- design/fsfa_pkg.sv -----
// shared types, constants and helpers for the frame source filter with arp rewrite
// used by fsfa_parse, fsfa_out_reg and frame_source_filter_arp_rewrite
// no dependencies
package fsfa_pkg;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_SRC_MAC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARP_SENDER_MAC  = 1'd1;

  // frame positions
  localparam logic [POS_W-1:0] POS_SRC_FIRST  = 5'd6;
  localparam logic [POS_W-1:0] POS_ETYPE_HI   = 5'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO   = 5'd13;
  localparam logic [POS_W-1:0] HEADER_LEN     = 5'd14;
  localparam logic [POS_W-1:0] POS_OPCODE_HI  = 5'd20;
  localparam logic [POS_W-1:0] POS_OPCODE_LO  = 5'd21;
  localparam logic [POS_W-1:0] POS_SENDER     = 5'd22;
  localparam logic [POS_W-1:0] POS_SENDER_END = 5'd28;
  localparam logic [POS_W-1:0] POS_MAX        = 5'd31;

  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [BYTE_W-1:0] ARP_OP_REQUEST = 8'd1;
  localparam logic [BYTE_W-1:0] ARP_OP_REPLY   = 8'd2;

  // one result item
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_end;
    logic [MAC_W-1:0]  next_hop_mac;
  } res_t;

  // frame tracking status seen by the top level
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             src_ok;
  } stat_t;

  // byte k of an address, byte 0 is the most significant
  function automatic logic [BYTE_W-1:0] mac_byte(input logic [MAC_W-1:0] mac,
                                                 input logic [2:0] k);
    logic [BYTE_W-1:0] b;
    case (k)
      3'd0:    b = mac[47:40];
      3'd1:    b = mac[39:32];
      3'd2:    b = mac[31:24];
      3'd3:    b = mac[23:16];
      3'd4:    b = mac[15:8];
      3'd5:    b = mac[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ----- design/fsfa_parse.sv -----
// input register, frame position tracking, source check and arp rewrite
// depends on fsfa_pkg
module fsfa_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fsfa_pkg::BYTE_W-1:0]   frame_byte_i,
  input  logic                          frame_end_i,
  input  logic                          space_i,
  input  logic [fsfa_pkg::MAC_W-1:0]    allowed_src_mac_i,
  input  logic [fsfa_pkg::MAC_W-1:0]    arp_sender_mac_i,
  output logic                          res_valid_o,
  output fsfa_pkg::res_t                res_o,
  output fsfa_pkg::stat_t               stat_o
);
  import fsfa_pkg::*;

  logic              vld_q;
  logic [BYTE_W-1:0] byte_q;
  logic              end_q;
  logic              fire;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic              src_ok_q, src_ok_d;
  logic              arp_q, arp_d;
  logic [MAC_W-1:0]  dst_q, dst_d;

  logic [POS_W-1:0]  src_off;
  logic [POS_W-1:0]  snd_off;
  logic              in_sender;

  // input register stage
  assign fire       = vld_q && space_i;
  assign in_ready_o = !vld_q || space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= frame_byte_i;
      end_q  <= frame_end_i;
    end
  end

  assign src_off   = pos_q - POS_SRC_FIRST;
  assign snd_off   = pos_q - POS_SENDER;
  assign in_sender = (pos_q >= POS_SENDER) && (pos_q < POS_SENDER_END);

  // header checks, destination address capture and position update
  always_comb begin
    pos_d    = pos_q;
    src_ok_d = src_ok_q;
    arp_d    = arp_q;
    dst_d    = dst_q;
    if (pos_q < POS_SRC_FIRST) begin
      dst_d = {dst_q[MAC_W-BYTE_W-1:0], byte_q};
    end else if (pos_q < POS_ETYPE_HI) begin
      if (byte_q != mac_byte(allowed_src_mac_i, src_off[2:0])) begin
        src_ok_d = 1'b0;
      end
    end else if (pos_q == POS_ETYPE_HI) begin
      if (byte_q != ETHERTYPE_ARP[15:8]) begin
        arp_d = 1'b0;
      end
    end else if (pos_q == POS_ETYPE_LO) begin
      if (byte_q != ETHERTYPE_ARP[7:0]) begin
        arp_d = 1'b0;
      end
    end else if (pos_q == POS_OPCODE_HI) begin
      if (byte_q != '0) begin
        arp_d = 1'b0;
      end
    end else if (pos_q == POS_OPCODE_LO) begin
      if (byte_q != ARP_OP_REQUEST && byte_q != ARP_OP_REPLY) begin
        arp_d = 1'b0;
      end
    end
    if (end_q) begin
      pos_d    = '0;
      src_ok_d = 1'b1;
      arp_d    = 1'b1;
    end else if (pos_q < POS_MAX) begin
      pos_d = pos_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      src_ok_q <= 1'b1;
      arp_q    <= 1'b1;
      dst_q    <= '0;
    end else if (fire) begin
      pos_q    <= pos_d;
      src_ok_q <= src_ok_d;
      arp_q    <= arp_d;
      dst_q    <= dst_d;
    end
  end

  // result for a payload byte of an accepted frame
  assign res_valid_o = vld_q && (pos_q >= HEADER_LEN) && src_ok_q;

  always_comb begin
    res_o.payload_byte = byte_q;
    if (arp_q && in_sender) begin
      res_o.payload_byte = mac_byte(arp_sender_mac_i, snd_off[2:0]);
    end
    res_o.payload_end  = end_q;
    res_o.next_hop_mac = dst_q;
  end

  assign stat_o.pos    = pos_q;
  assign stat_o.src_ok = src_ok_q;

endmodule

// ----- design/fsfa_out_reg.sv -----
// result register that holds an item until the output side takes it
// depends on fsfa_pkg
module fsfa_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  fsfa_pkg::res_t      res_i,
  output logic                space_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fsfa_pkg::res_t      out_o
);
  import fsfa_pkg::*;

  logic vld_q;
  res_t res_q;

  // free when empty or being drained this cycle
  assign space_o = !vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (space_o) begin
      vld_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (space_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_o       = res_q;

endmodule

// ----- design/frame_source_filter_arp_rewrite.sv -----
// frame source filter with arp sender rewrite, top level
// a payload item is registered in the input register and then in the result register before it is valid on the output
// throughput: one byte per cycle while the output takes items, set by the single input register and result register
// stalls on the output only hold the pipeline, the input keeps flowing while the result is free
// reset: asynchronous active low, clears frame tracking, address registers and valid flags
// depends on fsfa_pkg, fsfa_parse, fsfa_out_reg
module frame_source_filter_arp_rewrite (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fsfa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fsfa_pkg::MAC_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fsfa_pkg::BYTE_W-1:0]       frame_byte_i,
  input  logic                              frame_end_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fsfa_pkg::BYTE_W-1:0]       payload_byte_o,
  output logic                              payload_end_o,
  output logic [fsfa_pkg::MAC_W-1:0]        next_hop_mac_o
);
  import fsfa_pkg::*;

  logic [MAC_W-1:0] allowed_src_mac_q;
  logic [MAC_W-1:0] arp_sender_mac_q;
  logic             space;
  logic             res_valid;
  res_t             res;
  res_t             out;
  stat_t            stat;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allowed_src_mac_q <= '0;
      arp_sender_mac_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ALLOWED_SRC_MAC: allowed_src_mac_q <= cfg_data_i;
        CFG_ARP_SENDER_MAC:  arp_sender_mac_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // header tracking and payload selection
  fsfa_parse u_parse (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .frame_byte_i      (frame_byte_i),
    .frame_end_i       (frame_end_i),
    .space_i           (space),
    .allowed_src_mac_i (allowed_src_mac_q),
    .arp_sender_mac_i  (arp_sender_mac_q),
    .res_valid_o       (res_valid),
    .res_o             (res),
    .stat_o            (stat)
  );

  // result register
  fsfa_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out)
  );

  assign payload_byte_o = out.payload_byte;
  assign payload_end_o  = out.payload_end;
  assign next_hop_mac_o = out.next_hop_mac;

  // an empty result register never blocks the input
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // header bytes never produce a result item
  a_no_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> stat.pos >= HEADER_LEN)
    else $error("result item for a header byte");

  // a frame with a wrong source never produces a result item
  a_src_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> stat.src_ok)
    else $error("result item for a dropped frame");

endmodule
